// File: rtl/mime_word_payload_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
// Every module that uses them has ports named clock and reset.
`ifndef MIME_WORD_PAYLOAD_DECODER_MACROS_SVH
`define MIME_WORD_PAYLOAD_DECODER_MACROS_SVH

// Check cons in the same cycle as ante.
`define MWPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define MWPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mwpd_pkg.sv
package mwpd_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECODE_MODE         = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNDERSCORE_AS_SPACE = 1'd1;

   // Burst queue depth between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3D;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   typedef enum logic {
      MODE_BASE64 = 1'b0,
      MODE_QUOTED = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ESC_NONE   = 2'd0,
      ESC_EQUALS = 2'd1,
      ESC_DIGIT  = 2'd2
   } esc_type;

   // Up to three bytes caused by one input item; data[0] leaves first
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      count;
      logic            byte_valid;
      logic            word_done;
   } burst_type;

   // A base64 group ready for release
   typedef struct packed {
      logic [1:0]  count;
      logic [23:0] bits;
   } group_type;

endpackage

// File: rtl/mwpd_if.sv
// Input channel: one encoded character per item
interface mwpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_input;

   modport source (output valid, output symbol, output end_of_input, input ready);
   modport sink (input valid, input symbol, input end_of_input, output ready);
endinterface

// Result channel: one decoded byte or end marker per item
interface mwpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_of_run;
   logic       word_done;

   modport source (output valid, output data_byte, output byte_valid,
                   output last_of_run, output word_done, input ready);
   modport sink (input valid, input data_byte, input byte_valid,
                 input last_of_run, input word_done, output ready);
endinterface

// File: rtl/mwpd_front.sv
`include "mime_word_payload_decoder_macros.svh"

module mwpd_front
   import mwpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   mwpd_req_if.sink               req_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_write_data,
   input  logic                   queue_full,
   output logic                   push,
   output burst_type              push_data
);

   mode_type    decode_mode_ff;
   logic        underscore_as_space_ff;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [1:0]  pad_ff, pad_in;
   esc_type     esc_ff, esc_in;
   logic [7:0]  held_ff, held_in;
   logic        disc_ff, disc_in;

   logic        accept;
   logic        is_nul;
   logic        is_eq;
   logic [5:0]  sextet;
   logic [1:0]  pad_upd;
   logic [17:0] acc_shift;
   logic [7:0]  lit_symbol;
   logic [4:0]  hex_hi;
   logic [4:0]  hex_lo;
   esc_type     esc_step;
   logic [7:0]  held_step;
   logic        m_valid;
   logic [7:0]  m_byte;
   group_type   g_step;
   group_type   g_cur;
   burst_type   burst;
   logic [1:0]  fn;

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h41:8'h5A]}) begin
         d = c - 8'h41;
      end else if (c inside {[8'h61:8'h7A]}) begin
         d = c - 8'h61 + 8'h1A;
      end else if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30 + 8'h34;
      end else if (c == 8'h2B) begin
         d = 8'h3E;
      end else if (c == 8'h2F) begin
         d = 8'h3F;
      end
      return d[5:0];
   endfunction

   // bit 4 set marks a character that is no hex digit
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h10;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h41 + 8'h0A;
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h61 + 8'h0A;
      end
      return d[4:0];
   endfunction

   function automatic logic [7:0] literal_of(input logic [7:0] c, input logic uas);
      return (uas && c == CHAR_UNDERSCORE) ? CHAR_SPACE : c;
   endfunction

   function automatic logic [1:0] group_count(input logic [2:0] pads);
      return (pads >= 3'd3) ? 2'd0 : 2'(3'd3 - pads);
   endfunction

   // Treat a short group as padded out to four characters
   function automatic group_type flush_group(input logic [17:0] acc,
                                             input logic [1:0] k,
                                             input logic [1:0] pad);
      group_type g;
      g.bits  = 24'h0;
      g.count = 2'd0;
      case (k)
         2'd2: begin
            g.bits  = {acc[11:0], 12'h000};
            g.count = group_count(3'({1'b0, pad}) + 3'd2);
         end
         2'd3: begin
            g.bits  = {acc, 6'h00};
            g.count = group_count(3'({1'b0, pad}) + 3'd1);
         end
         default: begin
            g.count = 2'd0;
         end
      endcase
      return g;
   endfunction

   // Bytes released by an escape cut off at the end of the word
   function automatic logic [1:0] esc_flush_count(input esc_type ph);
      logic [1:0] n;
      case (ph)
         ESC_EQUALS: n = 2'd1;
         ESC_DIGIT:  n = 2'd2;
         default:    n = 2'd0;
      endcase
      return n;
   endfunction

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Classify the symbol
   assign is_nul     = req_chan.symbol == CHAR_NUL;
   assign is_eq      = req_chan.symbol == CHAR_EQUALS;
   assign sextet     = sextet_of(req_chan.symbol);
   assign pad_upd    = (is_eq && pad_ff != 2'd3) ? pad_ff + 2'd1 : pad_ff;
   assign acc_shift  = {acc_ff[11:0], sextet};
   assign lit_symbol = literal_of(req_chan.symbol, underscore_as_space_ff);
   assign hex_hi     = hex_of(held_ff);
   assign hex_lo     = hex_of(req_chan.symbol);

   // Quoted-printable step
   always_comb begin
      esc_step  = esc_ff;
      held_step = held_ff;
      m_valid   = 1'b0;
      m_byte    = lit_symbol;
      case (esc_ff)
         ESC_NONE: begin
            if (is_eq) begin
               esc_step = ESC_EQUALS;
            end else begin
               m_valid = 1'b1;
            end
         end
         ESC_EQUALS: begin
            held_step = req_chan.symbol;
            esc_step  = ESC_DIGIT;
         end
         default: begin
            m_valid   = !hex_hi[4] && !hex_lo[4];
            m_byte    = {hex_hi[3:0], hex_lo[3:0]};
            esc_step  = ESC_NONE;
            held_step = 8'h00;
         end
      endcase
   end

   // Base64 release: a full group, or the short group at end of word
   always_comb begin
      g_step.bits  = 24'h0;
      g_step.count = 2'd0;
      if (cnt_ff == 2'd3) begin
         g_step.bits  = {acc_ff, sextet};
         g_step.count = group_count({1'b0, pad_upd});
      end else if (req_chan.end_of_input) begin
         g_step = flush_group(acc_shift, cnt_ff + 2'd1, pad_upd);
      end
   end

   assign g_cur = flush_group(acc_ff, cnt_ff, pad_ff);

   // Next state
   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      pad_in  = pad_ff;
      esc_in  = esc_ff;
      held_in = held_ff;
      disc_in = disc_ff;
      if (accept) begin
         if (disc_ff) begin
            disc_in = disc_ff;
         end else if (is_nul) begin
            if (decode_mode_ff == MODE_QUOTED) begin
               esc_in  = ESC_NONE;
               held_in = 8'h00;
            end else begin
               acc_in = 18'h0;
               cnt_in = 2'd0;
               pad_in = 2'd0;
            end
            disc_in = 1'b1;
         end else if (decode_mode_ff == MODE_BASE64) begin
            if (cnt_ff == 2'd3) begin
               acc_in = 18'h0;
               cnt_in = 2'd0;
               pad_in = 2'd0;
            end else begin
               acc_in = acc_shift;
               cnt_in = cnt_ff + 2'd1;
               pad_in = pad_upd;
            end
         end else begin
            esc_in  = esc_step;
            held_in = held_step;
         end
         // End of word clears everything
         if (req_chan.end_of_input) begin
            acc_in  = 18'h0;
            cnt_in  = 2'd0;
            pad_in  = 2'd0;
            esc_in  = ESC_NONE;
            held_in = 8'h00;
            disc_in = 1'b0;
         end
      end
   end

   // Burst for the queue
   always_comb begin
      burst            = '0;
      burst.byte_valid = 1'b1;
      burst.word_done  = req_chan.end_of_input;
      fn               = 2'd0;
      if (disc_ff) begin
         burst.count = 2'd0;
      end else if (is_nul) begin
         if (decode_mode_ff == MODE_QUOTED) begin
            burst.count   = esc_flush_count(esc_ff);
            burst.data[0] = CHAR_EQUALS;
            burst.data[1] = literal_of(held_ff, underscore_as_space_ff);
         end else begin
            burst.count = g_cur.count;
            burst.data  = {g_cur.bits[7:0], g_cur.bits[15:8], g_cur.bits[23:16]};
         end
      end else if (decode_mode_ff == MODE_BASE64) begin
         burst.count = g_step.count;
         burst.data  = {g_step.bits[7:0], g_step.bits[15:8], g_step.bits[23:16]};
      end else begin
         if (req_chan.end_of_input) begin
            fn = esc_flush_count(esc_step);
         end
         if (m_valid) begin
            burst.data[0] = m_byte;
            burst.data[1] = CHAR_EQUALS;
            burst.data[2] = literal_of(held_step, underscore_as_space_ff);
            burst.count   = 2'd1 + fn;
         end else begin
            burst.data[0] = CHAR_EQUALS;
            burst.data[1] = literal_of(held_step, underscore_as_space_ff);
            burst.count   = fn;
         end
      end
      // Bare end marker when the word ends without a byte
      if (req_chan.end_of_input && burst.count == 2'd0) begin
         burst.data       = '0;
         burst.count      = 2'd1;
         burst.byte_valid = 1'b0;
      end
   end

   assign push      = accept && burst.count != 2'd0;
   assign push_data = burst;

   // Hold configuration and decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff         <= MODE_BASE64;
         underscore_as_space_ff <= 1'b0;
         acc_ff                 <= 18'h0;
         cnt_ff                 <= 2'd0;
         pad_ff                 <= 2'd0;
         esc_ff                 <= ESC_NONE;
         held_ff                <= 8'h00;
         disc_ff                <= 1'b0;
      end else begin
         if (csr_write_enable && csr_index == CSR_DECODE_MODE) begin
            decode_mode_ff <= mode_type'(csr_write_data);
         end
         if (csr_write_enable && csr_index == CSR_UNDERSCORE_AS_SPACE) begin
            underscore_as_space_ff <= csr_write_data;
         end
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         pad_ff  <= pad_in;
         esc_ff  <= esc_in;
         held_ff <= held_in;
         disc_ff <= disc_in;
      end
   end

   `MWPD_ASSERT_NEXT(a_word_end_clears, accept && req_chan.end_of_input, cnt_ff == 2'd0 && pad_ff == 2'd0 && esc_ff == ESC_NONE && !disc_ff, "state not cleared after end of word")

endmodule

// File: rtl/mwpd_queue.sv
`include "mime_word_payload_decoder_macros.svh"

module mwpd_queue
   import mwpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type push_data,
   output logic      full,
   input  logic      pop,
   output burst_type head,
   output logic      head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = mem[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the burst
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `MWPD_ASSERT_NOW(a_no_overflow, push, !full, "burst pushed into a full queue")
   `MWPD_ASSERT_NOW(a_no_underflow, pop, head_valid, "burst popped from an empty queue")

endmodule

// File: rtl/mwpd_back.sv
`include "mime_word_payload_decoder_macros.svh"

module mwpd_back
   import mwpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  burst_type  head,
   input  logic       head_valid,
   output logic       pop,
   mwpd_rsp_if.source rsp_chan
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] data_byte_ff;
   logic       byte_valid_ff;
   logic       last_of_run_ff;
   logic       word_done_ff;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_last;

   assign load    = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign at_last = idx_ff == head.count - 2'd1;
   assign pop     = load && at_last;

   // Step through the head burst one byte per item
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         idx_in       = at_last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         data_byte_ff   <= head.data[idx_ff];
         byte_valid_ff  <= head.byte_valid;
         last_of_run_ff <= at_last;
         word_done_ff   <= at_last && head.word_done;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data_byte   = data_byte_ff;
   assign rsp_chan.byte_valid  = byte_valid_ff;
   assign rsp_chan.last_of_run = last_of_run_ff;
   assign rsp_chan.word_done   = word_done_ff;

   `MWPD_ASSERT_NOW(a_done_is_last, rsp_valid_ff && word_done_ff, last_of_run_ff, "word end not on last item of run")
   `MWPD_ASSERT_NOW(a_marker_shape, rsp_valid_ff && !byte_valid_ff, word_done_ff && data_byte_ff == 8'h00, "bad bare end marker")

endmodule

// File: rtl/mime_word_payload_decoder.sv
// An item's first result passes through the burst queue and then the output register.
// Throughput: one input item per cycle while req ready is high; results leave one per cycle
// from the output register while rsp ready is high, so a three-byte item takes three results.
// The burst queue (QUEUE_DEPTH entries) absorbs that until it fills and req ready drops.
// Reset (synchronous, active high) selects base64 without underscore mapping, clears the
// decode state, empties the queue and drops result valid.
module mime_word_payload_decoder
   import mwpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   mwpd_req_if.sink               req_chan,
   mwpd_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_write_data
);

   logic      push;
   logic      pop;
   logic      queue_full;
   logic      head_valid;
   burst_type push_data;
   burst_type head;

   // Accept and decode characters into bursts
   mwpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_data        (push_data)
   );

   // Buffer bursts between the two sides
   mwpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // Serialise bursts into result items
   mwpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
